@@ rtl/rcpa_pkg.sv @@
`timescale 1ns / 1ps

package rcpa_pkg;

   // command codes
   localparam logic [2:0] CMD_ALLOC = 3'd0;
   localparam logic [2:0] CMD_FREE  = 3'd1;
   localparam logic [2:0] CMD_INIT  = 3'd2;
   localparam logic [2:0] CMD_INC   = 3'd3;
   localparam logic [2:0] CMD_DEC   = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_BADADDR = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_SAT     = 3'd4;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] phys_addr;
   } req_type;

   typedef struct packed {
      logic [31:0] page_addr;
      logic [15:0] ref_count;
      logic [12:0] free_pages;
      logic [2:0]  status;
   } rsp_type;

endpackage

@@ rtl/refcounted_page_allocator.sv @@
`timescale 1ns / 1ps

// Reference-counted physical page allocator. Free pages live on a LIFO stack of
// page indices held in one RAM; a second RAM holds a saturating reference count
// per page. Each request word carries a command (allocate, free, init-free,
// increment, decrement, read count) and a physical address, and produces exactly
// one response word with the allocated address, the page's count after the
// command, the free-stack depth and a status code. Every command is done in an
// accept step, which issues the reads of the count RAM and the top of the stack,
// and an execute state, which does the modify and write-back of both RAMs and
// loads the response register. Only one command is in flight, so accesses to
// the same entry never overlap. A new request is taken while an earlier
// response still waits; execution stalls only if that response is not yet
// taken when the next one is ready. After reset the count RAM is cleared one
// entry per cycle through all PAGE_COUNT entries, with req_ready low; csr writes
// are taken throughout. The pool starts empty: pages enter it by init-free or by
// a free to a zero count. The csr kernel end is the lowest address either accepts.
module refcounted_page_allocator
   import rcpa_pkg::*;
#(
   parameter int PAGE_COUNT  = 4096,
   parameter int PAGE_SHIFT  = 12,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_word,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_word,
   // kernel end register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IDX_W   = $clog2(PAGE_COUNT);
   localparam int DEPTH_W = $clog2(PAGE_COUNT + 1);
   localparam logic [31:0] PAGE_LIMIT = 32'(PAGE_COUNT);
   localparam logic [31:0] PAGE_MASK  = 32'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(PAGE_COUNT);
   localparam logic [IDX_W-1:0]   CLR_LAST   = IDX_W'(PAGE_COUNT - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [31:0]          kend_ff;
   req_type              hold_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // memories: count per page, free stack of page indices
   logic [COUNT_WIDTH-1:0] cnt_mem [PAGE_COUNT];
   logic [IDX_W-1:0]       stk_mem [PAGE_COUNT];
   logic [COUNT_WIDTH-1:0] cnt_rd_ff;
   logic [IDX_W-1:0]       stk_rd_ff;

   logic                   accept;
   logic                   exec_go;
   logic [31:0]            acc_page;
   logic [IDX_W-1:0]       acc_idx;
   logic [DEPTH_W-1:0]     depth_dec;
   logic [IDX_W-1:0]       stk_rd_addr;

   // execute-cycle decode
   logic [31:0]            page_num;
   logic                   idx_ok;
   logic                   free_ok;
   logic [IDX_W-1:0]       addr_idx;
   logic [COUNT_WIDTH-1:0] base_cnt;
   logic [COUNT_WIDTH-1:0] rel_cnt;
   logic [COUNT_WIDTH-1:0] cnt_out;
   logic [COUNT_WIDTH+15:0] cnt_wide;
   logic [DEPTH_W+12:0]    depth_wide;
   logic [31:0]            page_out;
   logic [2:0]             status;
   logic                   cnt_we;
   logic [IDX_W-1:0]       cnt_wa;
   logic [COUNT_WIDTH-1:0] cnt_wd;
   logic                   push;
   logic                   pop;

   // memory write port mux (clear sweep or execute)
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [COUNT_WIDTH-1:0] mem_wd;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // execute completes once the response register is free
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // read addresses, from the incoming word
   assign acc_page    = req_word.phys_addr >> PAGE_SHIFT;
   assign acc_idx     = acc_page[IDX_W-1:0];
   assign depth_dec   = depth_ff - DEPTH_W'(1);
   assign stk_rd_addr = depth_dec[IDX_W-1:0];  // top of stack; unused when empty

   // ------------------------------------------------------------------
   // command execution, one word at a time
   // ------------------------------------------------------------------
   assign page_num = hold_ff.phys_addr >> PAGE_SHIFT;
   assign idx_ok   = page_num < PAGE_LIMIT;
   assign free_ok  = ((hold_ff.phys_addr & PAGE_MASK) == 32'd0) &&
                     (hold_ff.phys_addr >= kend_ff) && idx_ok;
   assign addr_idx = page_num[IDX_W-1:0];

   // release: init-free starts from zero, count floors at zero
   assign base_cnt = (hold_ff.command == CMD_INIT) ? '0 : cnt_rd_ff;
   assign rel_cnt  = (base_cnt != '0) ? base_cnt - COUNT_WIDTH'(1) : '0;

   always_comb begin
      page_out = 32'd0;
      cnt_out  = '0;
      status   = ST_OK;
      cnt_we   = 1'b0;
      cnt_wa   = addr_idx;
      cnt_wd   = '0;
      push     = 1'b0;
      pop      = 1'b0;
      unique case (hold_ff.command)
         CMD_ALLOC: begin
            if (depth_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               pop      = 1'b1;
               cnt_we   = 1'b1;
               cnt_wa   = stk_rd_ff;
               cnt_wd   = COUNT_WIDTH'(1);
               cnt_out  = COUNT_WIDTH'(1);
               page_out = 32'(stk_rd_ff) << PAGE_SHIFT;
            end
         end
         CMD_FREE, CMD_INIT: begin
            if (!free_ok) begin
               status = ST_BADADDR;
            end else begin
               cnt_we  = 1'b1;
               cnt_wd  = rel_cnt;
               cnt_out = rel_cnt;
               if (rel_cnt == '0) begin
                  // full stack: count update stands, push dropped
                  if (depth_ff >= DEPTH_FULL) begin
                     status = ST_FULL;
                  end else begin
                     push = 1'b1;
                  end
               end
            end
         end
         CMD_INC: begin
            if (!idx_ok) begin
               status = ST_BADADDR;
            end else if (cnt_rd_ff == COUNT_MAX) begin
               status  = ST_SAT;
               cnt_out = cnt_rd_ff;
            end else begin
               cnt_we  = 1'b1;
               cnt_wd  = cnt_rd_ff + COUNT_WIDTH'(1);
               cnt_out = cnt_wd;
            end
         end
         CMD_DEC: begin
            if (!idx_ok) begin
               status = ST_BADADDR;
            end else if (cnt_rd_ff == '0) begin
               status = ST_SAT;
            end else begin
               cnt_we  = 1'b1;
               cnt_wd  = cnt_rd_ff - COUNT_WIDTH'(1);
               cnt_out = cnt_wd;
            end
         end
         CMD_READ: begin
            if (!idx_ok) begin
               status = ST_BADADDR;
            end else begin
               cnt_out = cnt_rd_ff;
            end
         end
         default: begin
            // unknown command: no effect
         end
      endcase
   end

   always_comb begin
      depth_in = depth_ff;
      if (exec_go && pop) begin
         depth_in = depth_dec;
      end else if (exec_go && push) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end
   end

   assign cnt_wide   = {16'd0, cnt_out};
   assign depth_wide = {13'd0, depth_in};

   always_comb begin
      rsp_in.page_addr  = page_out;
      rsp_in.ref_count  = cnt_wide[15:0];
      rsp_in.free_pages = depth_wide[12:0];
      rsp_in.status     = status;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         depth_ff     <= '0;
         kend_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            kend_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= req_word;
      end
      if (exec_go) begin
         rsp_ff <= rsp_in;
      end
   end

   // ------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------
   assign mem_we = (state_ff == S_CLEAR) || (exec_go && cnt_we);
   assign mem_wa = (state_ff == S_CLEAR) ? clr_ff : cnt_wa;
   assign mem_wd = (state_ff == S_CLEAR) ? '0 : cnt_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[mem_wa] <= mem_wd;
      end
      if (accept) begin
         cnt_rd_ff <= cnt_mem[acc_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go && push) begin
         stk_mem[depth_ff[IDX_W-1:0]] <= addr_idx;
      end
      if (accept) begin
         stk_rd_ff <= stk_mem[stk_rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_FULL)
      else $error("free stack depth beyond pool size");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      exec_go && (status == ST_FULL) |-> depth_ff == DEPTH_FULL)
      else $error("stack-full status with room on the stack");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC) && !req_ready)
      else $error("second word accepted while one executes");

   a_exec_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_go |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("executed word did not reach the response register");
`endif

endmodule
